// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the priority table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Implication checked on every rising edge outside reset.
`define ASSERT_CLKD(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLKD(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: hw/rtl/ptp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared types and constants of the priority table with promote.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_PROMOTE = 3'd1,
    OP_PEEK    = 3'd2,
    OP_POP     = 3'd3,
    OP_LOOKUP  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

// File: hw/rtl/ptp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_ctrl
// Sequencer for one operation: load, slot scan, drain, finish.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output ptp_pkg::cmd_t cmd,
  input  ptp_pkg::sts_t sts
);

  ptp_pkg::state_t state_r;
  ptp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state_r)
      ptp_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ptp_pkg::S_SCAN;
        end
      end
      ptp_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ptp_pkg::S_DRAIN;
        end
      end
      ptp_pkg::S_DRAIN: begin
        state_nxt = ptp_pkg::S_FINISH;
      end
      ptp_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ptp_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ptp_pkg::S_IDLE;
      end
    endcase
  end

  `ASSERT_CLKD(a_start_enters_scan, clk, rst_n,
    (state_r == ptp_pkg::S_IDLE && start) |=> (state_r == ptp_pkg::S_SCAN))
  `ASSERT_CLKD(a_finish_returns_idle, clk, rst_n,
    (state_r == ptp_pkg::S_FINISH) |=> (state_r == ptp_pkg::S_IDLE && !busy))

endmodule

// File: hw/rtl/ptp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_datapath
// Slot memories, scan counter, best-candidate compare and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptp_datapath #(
  parameter int unsigned CAPACITY   = ptp_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = ptp_pkg::VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ptp_pkg::cmd_t cmd,
  output ptp_pkg::sts_t sts,
  input  logic [2:0]    in_operation,
  input  logic [31:0]   in_item_value,
  input  logic [31:0]   in_item_id,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic [31:0]   out_id,
  output logic [31:0]   out_value,
  output logic [31:0]   out_priority,
  output logic          out_present
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  // Slot storage.
  logic [31:0]           id_mem  [CAPACITY];
  logic [31:0]           pri_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];
  logic [CAPACITY-1:0]   used_r;

  // Latched operation.
  ptp_pkg::op_t          op_r;
  logic [VALUE_BITS-1:0] item_val_r;
  logic [31:0]           item_id_r;
  logic [31:0]           next_id_r;

  // Scan pipeline.
  logic [IDX_W-1:0]      scan_cnt_r;
  logic                  rd_vld_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic                  used_rd_r;
  logic [31:0]           id_rd_r;
  logic [31:0]           pri_rd_r;
  logic [VALUE_BITS-1:0] val_rd_r;

  // Best candidate so far.
  logic                  found_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [31:0]           best_id_r;
  logic [31:0]           best_pri_r;
  logic [VALUE_BITS-1:0] best_val_r;

  logic                  take;
  logic [31:0]           pri_inc;

  // Finish-cycle decisions.
  logic                  wr_all;
  logic                  wr_pri;
  logic                  set_used;
  logic                  clr_used;
  logic [1:0]            res_status;
  logic [31:0]           res_id;
  logic [31:0]           res_value;
  logic [31:0]           res_priority;
  logic                  res_present;

  assign sts.scan_last = (scan_cnt_r == IDX_W'(CAPACITY - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= ptp_pkg::op_t'(in_operation);
      item_val_r <= VALUE_BITS'(in_item_value);
      item_id_r  <= in_item_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      rd_vld_r   <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.load) begin
        scan_cnt_r <= '0;
        found_r    <= 1'b0;
      end else begin
        if (cmd.scan) begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
        end
        if (take) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  // Registered slot read at the scan address.
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_idx_r  <= scan_cnt_r;
      used_rd_r <= used_r[scan_cnt_r];
      id_rd_r   <= id_mem[scan_cnt_r];
      pri_rd_r  <= pri_mem[scan_cnt_r];
      val_rd_r  <= val_mem[scan_cnt_r];
    end
  end

  always_comb begin
    take = 1'b0;
    if (rd_vld_r) begin
      case (op_r) inside
        ptp_pkg::OP_ADD: begin
          take = !used_rd_r && !found_r;
        end
        ptp_pkg::OP_PROMOTE, ptp_pkg::OP_LOOKUP: begin
          take = used_rd_r && !found_r && (id_rd_r == item_id_r);
        end
        ptp_pkg::OP_PEEK, ptp_pkg::OP_POP: begin
          take = used_rd_r && (!found_r || (pri_rd_r > best_pri_r) ||
                 ((pri_rd_r == best_pri_r) && (id_rd_r > best_id_r)));
        end
        default: begin
          take = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r <= rd_idx_r;
      best_id_r  <= id_rd_r;
      best_pri_r <= pri_rd_r;
      best_val_r <= val_rd_r;
    end
  end

  assign pri_inc = (best_pri_r == '1) ? best_pri_r : best_pri_r + 32'd1;

  always_comb begin
    wr_all       = 1'b0;
    wr_pri       = 1'b0;
    set_used     = 1'b0;
    clr_used     = 1'b0;
    res_status   = ptp_pkg::ST_OK;
    res_id       = '0;
    res_value    = '0;
    res_priority = '0;
    res_present  = 1'b0;
    case (op_r) inside
      ptp_pkg::OP_ADD: begin
        if (!found_r) begin
          res_status = ptp_pkg::ST_FULL;
        end else begin
          wr_all    = 1'b1;
          set_used  = 1'b1;
          res_id    = next_id_r;
          res_value = 32'(item_val_r);
        end
      end
      ptp_pkg::OP_PROMOTE: begin
        if (!found_r) begin
          res_status = ptp_pkg::ST_UNKNOWN;
        end else begin
          wr_pri       = 1'b1;
          res_id       = best_id_r;
          res_value    = 32'(best_val_r);
          res_priority = pri_inc;
        end
      end
      ptp_pkg::OP_PEEK, ptp_pkg::OP_POP: begin
        if (!found_r) begin
          res_status = ptp_pkg::ST_EMPTY;
        end else begin
          clr_used     = (op_r == ptp_pkg::OP_POP);
          res_id       = best_id_r;
          res_value    = 32'(best_val_r);
          res_priority = best_pri_r;
        end
      end
      ptp_pkg::OP_LOOKUP: begin
        if (!found_r) begin
          res_status = ptp_pkg::ST_UNKNOWN;
        end else begin
          res_id       = best_id_r;
          res_value    = 32'(best_val_r);
          res_priority = best_pri_r;
          res_present  = 1'b1;
        end
      end
      default: begin
        res_status = ptp_pkg::ST_OK;
      end
    endcase
  end

  // Slot writes happen only in the finish cycle, never during a scan.
  always_ff @(posedge clk) begin
    if (cmd.finish && wr_all) begin
      id_mem[best_idx_r]  <= next_id_r;
      val_mem[best_idx_r] <= item_val_r;
    end
    if (cmd.finish && (wr_all || wr_pri)) begin
      pri_mem[best_idx_r] <= wr_all ? 32'd0 : pri_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      next_id_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
      if (cmd.finish && set_used) begin
        used_r[best_idx_r] <= 1'b1;
        next_id_r          <= next_id_r + 32'd1;
      end
      if (cmd.finish && clr_used) begin
        used_r[best_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status   <= res_status;
      out_id       <= res_id;
      out_value    <= res_value;
      out_priority <= res_priority;
      out_present  <= res_present;
    end
  end

  `ASSERT_CLKD(a_result_one_cycle, clk, rst_n, out_valid |=> !out_valid)
  `ASSERT_NEVER(a_no_scan_at_finish, clk, rst_n, cmd.finish && (cmd.scan || rd_vld_r))

endmodule

// File: hw/rtl/priority_table_with_promote.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_table_with_promote
// Fixed table of items with add, promote, peek-max, pop-max and lookup.
// ----------------------------------------------------------------------------
// Usage: present an operation on in_operation, in_item_value and in_item_id
// and raise start. The beat is taken at a rising edge where start is high and
// busy is low; busy then stays high until the operation has finished.
// Every operation scans all CAPACITY slots through one read port of the slot
// memories, one slot per cycle, with a single comparator that keeps the best
// candidate (first free slot, first matching id, or highest priority with the
// larger id winning ties). After the scan come the drain and finish states;
// the finish state writes the chosen slot and loads the result registers.
// The result beat appears on the out_ ports for exactly one cycle, marked by
// out_valid, which is registered from the finish state. busy drops in that
// same cycle, so a new beat is taken only once the previous one has finished.
// The receiver cannot stall the result; it must take it when out_valid is high.
// Reset (rst_n low at a rising edge) empties the table, zeroes the id counter
// and returns the sequencer to idle; no clearing pass is needed because slot
// occupancy is held in flip-flops.
// ----------------------------------------------------------------------------

module priority_table_with_promote #(
  parameter int unsigned CAPACITY   = ptp_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = ptp_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_item_value,
  input  logic [31:0] in_item_id,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_id,
  output logic [31:0] out_value,
  output logic [31:0] out_priority,
  output logic        out_present
);

  ptp_pkg::cmd_t cmd;
  ptp_pkg::sts_t sts;

  // The controller sequences the scan; it sees only start and scan_last.
  ptp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // The datapath holds the slots, the id counter and the result registers.
  ptp_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_operation  (in_operation),
    .in_item_value (in_item_value),
    .in_item_id    (in_item_id),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_id        (out_id),
    .out_value     (out_value),
    .out_priority  (out_priority),
    .out_present   (out_present)
  );

endmodule
